FILE: sv/pcmi_pkg.sv
`timescale 1ns / 1ps
package pcmi_pkg;

   localparam int DEFAULT_DEPTH = 256;
   localparam int DEN_W         = 33;   // |difference of two Q16.16 values|
   localparam int FRAC_W        = 16;
   localparam int COLOR_W       = 17;
   localparam int SLOPE_W       = 18;
   localparam int INDEX_W       = 8;

   localparam logic [1:0] CSR_DATA_MIN    = 2'd0;
   localparam logic [1:0] CSR_DATA_MAX    = 2'd1;
   localparam logic [1:0] CSR_PAL_ENABLED = 2'd2;

   typedef enum logic [2:0] {
      KIND_GRAY,
      KIND_LOW,
      KIND_HIGH,
      KIND_INTERP,
      KIND_LOAD
   } kind_type;

   // Per-item sideband that rides alongside the divider.
   typedef struct packed {
      kind_type                 kind;
      logic                     gray_hi;
      logic [INDEX_W-1:0]       index;
      logic [3*COLOR_W-1:0]     colors;   // {red, green, blue}
      logic [3*SLOPE_W-1:0]     slopes;   // {red, green, blue}
   } side_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pix_type;

endpackage

FILE: sv/pcmi_ram.sv
`timescale 1ns / 1ps
module pcmi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/pcmi_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
// Expects in_num >> LOW_W < in_den, so quotient fits LOW_W + FRAC_W bits.
module pcmi_div #(
   parameter int LOW_W = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic                                   in_valid,
   input  logic [pcmi_pkg::DEN_W+LOW_W-1:0]       in_num,
   input  logic [pcmi_pkg::DEN_W-1:0]             in_den,
   input  pcmi_pkg::side_type                     in_side,
   output logic                                   out_valid,
   output logic [LOW_W+pcmi_pkg::FRAC_W-1:0]      out_quo,
   output pcmi_pkg::side_type                     out_side
);
   import pcmi_pkg::*;

   localparam int QW = LOW_W + FRAC_W;

   logic [DEN_W-1:0] rem_ff  [QW];
   logic [QW-1:0]    bits_ff [QW];
   logic [QW-1:0]    quo_ff  [QW];
   logic [DEN_W-1:0] den_ff  [QW];
   side_type         side_ff [QW];
   logic             valid_ff [QW];

   logic [DEN_W-1:0] rem_src  [QW];
   logic [QW-1:0]    bits_src [QW];
   logic [QW-1:0]    quo_src  [QW];
   logic [DEN_W-1:0] den_src  [QW];
   side_type         side_src [QW];
   logic             valid_src [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      logic             ge;
      logic [DEN_W-1:0] rem_in;

      if (k == 0) begin : g_first
         assign rem_src[k]   = in_num[DEN_W+LOW_W-1:LOW_W];
         assign bits_src[k]  = {in_num[LOW_W-1:0], {FRAC_W{1'b0}}};
         assign quo_src[k]   = '0;
         assign den_src[k]   = in_den;
         assign side_src[k]  = in_side;
         assign valid_src[k] = in_valid;
      end else begin : g_next
         assign rem_src[k]   = rem_ff[k-1];
         assign bits_src[k]  = bits_ff[k-1];
         assign quo_src[k]   = quo_ff[k-1];
         assign den_src[k]   = den_ff[k-1];
         assign side_src[k]  = side_ff[k-1];
         assign valid_src[k] = valid_ff[k-1];
      end

      assign trial  = {rem_src[k], bits_src[k][QW-1]};
      assign ge     = trial >= {1'b0, den_src[k]};
      assign diff   = trial - {1'b0, den_src[k]};
      assign rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_src[k];
         end
         if (en) begin
            rem_ff[k]  <= rem_in;
            bits_ff[k] <= {bits_src[k][QW-2:0], 1'b0};
            quo_ff[k]  <= {quo_src[k][QW-2:0], ge};
            den_ff[k]  <= den_src[k];
            side_ff[k] <= side_src[k];
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_quo   = quo_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

FILE: sv/palette_colormap_interpolator_core.sv
`timescale 1ns / 1ps
// A req beat passes stages 0-2, the divider, the palette read, stage P and the output
// register to rsp_valid. Throughput: one beat per cycle while req_stall is low; the position
// divider has one stage per quotient bit; the palettes take a read and a write per cycle.
// Reset (synchronous, active high) clears pipeline valids, output/skid valids and
// the CSRs (data_min 0, data_max 1.0, palette off); palette memories are not cleared.
module palette_colormap_interpolator_core #(
   parameter int PALETTE_DEPTH = pcmi_pkg::DEFAULT_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   // input channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_cmd,
   input  logic signed [31:0]            req_sample,
   input  logic [pcmi_pkg::INDEX_W-1:0]  req_entry_index,
   input  logic [pcmi_pkg::COLOR_W-1:0]  req_entry_red,
   input  logic [pcmi_pkg::COLOR_W-1:0]  req_entry_green,
   input  logic [pcmi_pkg::COLOR_W-1:0]  req_entry_blue,
   input  logic signed [pcmi_pkg::SLOPE_W-1:0] req_slope_red,
   input  logic signed [pcmi_pkg::SLOPE_W-1:0] req_slope_green,
   input  logic signed [pcmi_pkg::SLOPE_W-1:0] req_slope_blue,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_red_out,
   output logic [7:0]                    rsp_green_out,
   output logic [7:0]                    rsp_blue_out,
   // CSR write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [31:0]                   csr_data
);
   import pcmi_pkg::*;

   localparam int AW    = $clog2(PALETTE_DEPTH);
   localparam int TOP_W = AW;
   localparam int QW    = TOP_W + FRAC_W;
   localparam int NW    = DEN_W + TOP_W;
   localparam logic [TOP_W-1:0] TOP = TOP_W'(PALETTE_DEPTH - 1);

   // ---------------------------------------------------------------- CSRs
   logic signed [31:0] data_min_ff;
   logic signed [31:0] data_max_ff;
   logic               pal_en_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_min_ff <= '0;
         data_max_ff <= 32'sd65536;
         pal_en_ff   <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DATA_MIN:    data_min_ff <= csr_data;
            CSR_DATA_MAX:    data_max_ff <= csr_data;
            CSR_PAL_ENABLED: pal_en_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------- pipeline enable
   // Whole pipe moves together; it freezes only when the skid stage is full.
   logic out_v_ff, skid_v_ff;
   logic en;
   assign en        = !skid_v_ff;
   assign req_stall = skid_v_ff;

   logic accept;
   assign accept = req_valid && !req_stall;

   // ---------------------------------------------------- stage 0: offsets
   logic signed [DEN_W-1:0] s0_num_in, s0_den_in;
   assign s0_num_in = DEN_W'(req_sample) - DEN_W'(data_min_ff);
   assign s0_den_in = DEN_W'(data_max_ff) - DEN_W'(data_min_ff);

   logic                    s0_valid_ff;
   logic signed [DEN_W-1:0] s0_num_ff, s0_den_ff;
   logic                    s0_gray_ff, s0_gray_hi_ff, s0_cmd_ff;
   logic [INDEX_W-1:0]      s0_index_ff;
   logic [3*COLOR_W-1:0]    s0_colors_ff;
   logic [3*SLOPE_W-1:0]    s0_slopes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= accept;
      end
      if (en) begin
         s0_num_ff     <= s0_num_in;
         s0_den_ff     <= s0_den_in;
         // gray threshold when palette is off or the bounds coincide
         s0_gray_ff    <= !pal_en_ff || (data_min_ff == data_max_ff);
         s0_gray_hi_ff <= req_sample > data_max_ff;
         s0_cmd_ff     <= req_cmd;
         s0_index_ff   <= req_entry_index;
         s0_colors_ff  <= {req_entry_red, req_entry_green, req_entry_blue};
         s0_slopes_ff  <= {req_slope_red, req_slope_green, req_slope_blue};
      end
   end

   // ---------------------------------------------- stage 1: magnitudes, kind
   logic [DEN_W-1:0] s1_n_in, s1_d_in;
   kind_type         s1_kind_in;
   side_type         s1_side_in;

   assign s1_n_in = s0_num_ff[DEN_W-1] ? DEN_W'(-s0_num_ff) : DEN_W'(s0_num_ff);
   assign s1_d_in = s0_den_ff[DEN_W-1] ? DEN_W'(-s0_den_ff) : DEN_W'(s0_den_ff);

   always_comb begin
      if (s0_cmd_ff) begin
         s1_kind_in = KIND_LOAD;
      end else if (s0_gray_ff) begin
         s1_kind_in = KIND_GRAY;
      end else if (s0_num_ff == '0 || (s0_num_ff[DEN_W-1] != s0_den_ff[DEN_W-1])) begin
         // at or below the low bound: first entry, flat
         s1_kind_in = KIND_LOW;
      end else if (s1_n_in >= s1_d_in) begin
         // at or above the high bound: last entry, flat
         s1_kind_in = KIND_HIGH;
      end else begin
         s1_kind_in = KIND_INTERP;
      end
      s1_side_in.kind    = s1_kind_in;
      s1_side_in.gray_hi = s0_gray_hi_ff;
      s1_side_in.index   = s0_index_ff;
      s1_side_in.colors  = s0_colors_ff;
      s1_side_in.slopes  = s0_slopes_ff;
   end

   logic             s1_valid_ff;
   logic [DEN_W-1:0] s1_n_ff, s1_d_ff;
   side_type         s1_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= s0_valid_ff;
      end
      if (en) begin
         s1_n_ff    <= s1_n_in;
         s1_d_ff    <= s1_d_in;
         s1_side_ff <= s1_side_in;
      end
   end

   // ------------------------------------------------ stage 2: n * TOP
   logic [NW-1:0] s2_prod_in;
   assign s2_prod_in = NW'({{TOP_W{1'b0}}, s1_n_ff} * {{DEN_W{1'b0}}, TOP});

   logic             s2_valid_ff;
   logic [NW-1:0]    s2_prod_ff;
   logic [DEN_W-1:0] s2_d_ff;
   side_type         s2_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (en) begin
         s2_prod_ff <= s2_prod_in;
         s2_d_ff    <= s1_d_ff;
         s2_side_ff <= s1_side_ff;
      end
   end

   // ------------------------------- divider: xq = n*TOP*2^16 / d, QW stages
   logic          dv_valid;
   logic [QW-1:0] dv_quo;
   side_type      dv_side;

   pcmi_div #(
      .LOW_W (TOP_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s2_valid_ff),
      .in_num    (s2_prod_ff),
      .in_den    (s2_d_ff),
      .in_side   (s2_side_ff),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   // ------------------------------------- palette access (read or write)
   // Loads travel the same pipe as converts, so memory accesses happen in
   // beat order and any later read of a written entry sees the new data.
   logic [TOP_W-1:0] pos_idx;
   logic [AW-1:0]    mem_addr;
   logic             load_ok, mem_we;

   assign pos_idx = (dv_quo[QW-1:FRAC_W] > TOP) ? TOP : dv_quo[QW-1:FRAC_W];
   assign load_ok = int'(dv_side.index) < PALETTE_DEPTH;

   always_comb begin
      case (dv_side.kind)
         KIND_LOAD: mem_addr = AW'(dv_side.index);
         KIND_HIGH: mem_addr = TOP;
         KIND_LOW:  mem_addr = '0;
         default:   mem_addr = pos_idx;
      endcase
   end

   assign mem_we = en && dv_valid && (dv_side.kind == KIND_LOAD) && load_ok;

   logic [3*COLOR_W-1:0] rd_colors;
   logic [3*SLOPE_W-1:0] rd_slopes;

   pcmi_ram #(
      .WIDTH (3*COLOR_W),
      .DEPTH (PALETTE_DEPTH)
   ) u_colors (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_addr),
      .wdata (dv_side.colors),
      .re    (en),
      .raddr (mem_addr),
      .rdata (rd_colors)
   );

   pcmi_ram #(
      .WIDTH (3*SLOPE_W),
      .DEPTH (PALETTE_DEPTH)
   ) u_slopes (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_addr),
      .wdata (dv_side.slopes),
      .re    (en),
      .raddr (mem_addr),
      .rdata (rd_slopes)
   );

   logic              sr_valid_ff;
   logic [FRAC_W-1:0] sr_frac_ff;
   kind_type          sr_kind_ff;
   logic              sr_gray_hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sr_valid_ff <= 1'b0;
      end else if (en) begin
         sr_valid_ff <= dv_valid;
      end
      if (en) begin
         sr_frac_ff    <= dv_quo[FRAC_W-1:0];
         sr_kind_ff    <= dv_side.kind;
         sr_gray_hi_ff <= dv_side.gray_hi;
      end
   end

   // --------------------------- stage P: color + frac*slope, color*255
   localparam int V_W  = COLOR_W + FRAC_W + 2;  // signed Q.32 channel
   localparam int EP_W = COLOR_W + 8;

   logic signed [V_W-1:0] sp_v_in  [3];
   logic [EP_W-1:0]       sp_ep_in [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sp_v_in[c] = $signed({2'b00, rd_colors[(2-c)*COLOR_W +: COLOR_W], {FRAC_W{1'b0}}})
                    + V_W'($signed({1'b0, sr_frac_ff})
                           * $signed(rd_slopes[(2-c)*SLOPE_W +: SLOPE_W]));
         sp_ep_in[c] = EP_W'(rd_colors[(2-c)*COLOR_W +: COLOR_W] * 8'd255);
      end
   end

   logic                  sp_valid_ff;
   kind_type              sp_kind_ff;
   logic                  sp_gray_hi_ff;
   logic signed [V_W-1:0] sp_v_ff  [3];
   logic [EP_W-1:0]       sp_ep_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_valid_ff <= 1'b0;
      end else if (en) begin
         sp_valid_ff <= sr_valid_ff;
      end
      if (en) begin
         sp_kind_ff    <= sr_kind_ff;
         sp_gray_hi_ff <= sr_gray_hi_ff;
         sp_v_ff       <= sp_v_in;
         sp_ep_ff      <= sp_ep_in;
      end
   end

   // -------------------------------------------- byte scaling and clamp
   localparam int W_W = V_W - 1 + 8;

   logic [7:0]     byte_in [3];
   logic [W_W-1:0] scaled  [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         scaled[c] = W_W'(sp_v_ff[c][V_W-2:0] * 8'd255);
         case (sp_kind_ff)
            KIND_GRAY: begin
               byte_in[c] = sp_gray_hi_ff ? 8'd255 : 8'd0;
            end
            KIND_LOW, KIND_HIGH: begin
               byte_in[c] = sp_ep_ff[c][EP_W-1] ? 8'd255 : sp_ep_ff[c][EP_W-2:FRAC_W];
            end
            KIND_INTERP: begin
               if (sp_v_ff[c] <= 0) begin
                  byte_in[c] = 8'd0;
               end else if (scaled[c][W_W-1:40] != '0) begin
                  byte_in[c] = 8'd255;
               end else begin
                  byte_in[c] = scaled[c][39:32];
               end
            end
            default: begin
               byte_in[c] = 8'd0;
            end
         endcase
      end
   end

   pix_type new_pix;
   logic    new_v;
   assign new_pix = '{red: byte_in[0], green: byte_in[1], blue: byte_in[2]};
   assign new_v   = en && sp_valid_ff && (sp_kind_ff != KIND_LOAD);

   // ------------------------------------------- output register + skid
   pix_type out_pix_ff, skid_pix_ff;
   logic    take;
   assign take = out_v_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (new_v) begin
            if (!out_v_ff || take) begin
               out_v_ff <= 1'b1;
            end else begin
               skid_v_ff <= 1'b1;
            end
         end else if (skid_v_ff && take) begin
            skid_v_ff <= 1'b0;
         end else if (take) begin
            out_v_ff <= 1'b0;
         end
      end
      if (new_v) begin
         if (!out_v_ff || take) begin
            out_pix_ff <= new_pix;
         end else begin
            skid_pix_ff <= new_pix;
         end
      end else if (skid_v_ff && take) begin
         out_pix_ff <= skid_pix_ff;
      end
   end

   assign rsp_valid     = out_v_ff;
   assign rsp_red_out   = out_pix_ff.red;
   assign rsp_green_out = out_pix_ff.green;
   assign rsp_blue_out  = out_pix_ff.blue;

endmodule
